[hw/rtl/pal_pkg.sv]
// ============================================================================
// Positional array list package
// Shared types, sizes and codes for the list controller, datapath and top.
// ============================================================================
`default_nettype none

package pal_pkg;

   // List sizes
   localparam int CAPACITY = 64;
   localparam int ADDR_W   = 6;
   localparam int COUNT_W  = 7;

   // Command codes
   localparam logic [2:0] OP_INSERT  = 3'd0;
   localparam logic [2:0] OP_DELETE  = 3'd1;
   localparam logic [2:0] OP_SEARCH  = 3'd2;
   localparam logic [2:0] OP_UPDATE  = 3'd3;
   localparam logic [2:0] OP_DISPLAY = 3'd4;

   // Status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BADPOS   = 3'd1;
   localparam logic [2:0] ST_EMPTY    = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;

   // Walk pointer operations
   localparam logic [2:0] PTR_HOLD  = 3'd0;
   localparam logic [2:0] PTR_COUNT = 3'd1;
   localparam logic [2:0] PTR_POS   = 3'd2;
   localparam logic [2:0] PTR_ZERO  = 3'd3;
   localparam logic [2:0] PTR_INC   = 3'd4;
   localparam logic [2:0] PTR_DEC   = 3'd5;

   // Fill count operations
   localparam logic [1:0] CNT_HOLD = 2'd0;
   localparam logic [1:0] CNT_INC  = 2'd1;
   localparam logic [1:0] CNT_DEC  = 2'd2;

   // Read address selection
   localparam logic [1:0] RD_PTR  = 2'd0;
   localparam logic [1:0] RD_PREV = 2'd1;
   localparam logic [1:0] RD_NEXT = 2'd2;

   // Command transaction payload
   typedef struct packed {
      logic [2:0]         op;
      logic [6:0]         position;
      logic signed [31:0] operand_value;
   } req_type;

   // Result transaction payload
   typedef struct packed {
      logic [2:0]         status;
      logic [5:0]         found_index;
      logic signed [31:0] element;
      logic [6:0]         fill_count;
      logic               end_of_run;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       load_req;
      logic [2:0] ptr_op;
      logic [1:0] cnt_op;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       mv_en;
      logic       wr_val_en;
      logic       emit;
      logic [2:0] status;
      logic       use_found;
      logic       use_element;
      logic       last;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [2:0] op;
      logic       pos_gt_count;
      logic       pos_ge_count;
      logic       count_zero;
      logic       count_full;
      logic       ptr_gt_pos;
      logic       ptr_next_lt_count;
      logic       key_match;
      logic       out_free;
   } stat_type;

endpackage

`default_nettype wire

[hw/rtl/pal_datapath.sv]
// ============================================================================
// Positional array list datapath
// Entry memory, fill count, walk pointer, request latch and result register.
// ============================================================================
`default_nettype none

module pal_datapath (
   input  wire                   clock,
   input  wire                   reset,
   input  pal_pkg::req_type      req_data,
   input  pal_pkg::cmd_type      cmd,
   output pal_pkg::stat_type     stat,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output pal_pkg::rsp_type      rsp_data
);

   // Entry memory and its registered read data
   logic signed [31:0] entries_ff [pal_pkg::CAPACITY];
   logic signed [31:0] rd_data_ff;
   logic [pal_pkg::ADDR_W-1:0] rd_addr;

   // Pending write-back of a moved entry
   logic                       mv_pend_ff, mv_pend_in;
   logic [pal_pkg::ADDR_W-1:0] mv_dst_ff, mv_dst_in;

   logic [pal_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [pal_pkg::COUNT_W-1:0] ptr_ff, ptr_in;
   logic [pal_pkg::COUNT_W:0]   ptr_next;
   pal_pkg::req_type            req_ff, req_in;
   pal_pkg::rsp_type            rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   assign ptr_next = {1'b0, ptr_ff} + {{pal_pkg::COUNT_W{1'b0}}, 1'b1};

   // Read address for a move or a scan step
   always_comb begin
      case (cmd.rd_sel)
         pal_pkg::RD_PREV: rd_addr = pal_pkg::ADDR_W'(ptr_ff - 7'd1);
         pal_pkg::RD_NEXT: rd_addr = ptr_next[pal_pkg::ADDR_W-1:0];
         default:          rd_addr = ptr_ff[pal_pkg::ADDR_W-1:0];
      endcase
   end

   // Memory: one read port, one write port shared by moves and value writes
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= entries_ff[rd_addr];
      end
      if (mv_pend_ff) begin
         entries_ff[mv_dst_ff] <= rd_data_ff;
      end else if (cmd.wr_val_en) begin
         entries_ff[req_ff.position[pal_pkg::ADDR_W-1:0]] <= req_ff.operand_value;
      end
   end

   // Next values of the control and payload registers
   always_comb begin
      mv_pend_in = cmd.rd_en & cmd.mv_en;
      mv_dst_in  = ptr_ff[pal_pkg::ADDR_W-1:0];
      req_in     = cmd.load_req ? req_data : req_ff;

      case (cmd.cnt_op)
         pal_pkg::CNT_INC: count_in = count_ff + 7'd1;
         pal_pkg::CNT_DEC: count_in = count_ff - 7'd1;
         default:          count_in = count_ff;
      endcase

      case (cmd.ptr_op)
         pal_pkg::PTR_COUNT: ptr_in = count_ff;
         pal_pkg::PTR_POS:   ptr_in = req_ff.position;
         pal_pkg::PTR_ZERO:  ptr_in = '0;
         pal_pkg::PTR_INC:   ptr_in = ptr_next[pal_pkg::COUNT_W-1:0];
         pal_pkg::PTR_DEC:   ptr_in = ptr_ff - 7'd1;
         default:            ptr_in = ptr_ff;
      endcase

      rsp_in.status      = cmd.status;
      rsp_in.found_index = cmd.use_found ? ptr_ff[pal_pkg::ADDR_W-1:0] : '0;
      rsp_in.element     = cmd.use_element ? rd_data_ff : '0;
      rsp_in.fill_count  = count_ff;
      rsp_in.end_of_run  = cmd.last;
      if (!cmd.emit) begin
         rsp_in = rsp_ff;
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         mv_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         mv_pend_ff   <= mv_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mv_dst_ff <= mv_dst_in;
      ptr_ff    <= ptr_in;
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
   end

   // Status toward the controller
   always_comb begin
      stat.op                = req_ff.op;
      stat.pos_gt_count      = req_ff.position > count_ff;
      stat.pos_ge_count      = req_ff.position >= count_ff;
      stat.count_zero        = count_ff == '0;
      stat.count_full        = count_ff == pal_pkg::COUNT_W'(pal_pkg::CAPACITY);
      stat.ptr_gt_pos        = ptr_ff > req_ff.position;
      stat.ptr_next_lt_count = ptr_next < {1'b0, count_ff};
      stat.key_match         = rd_data_ff == req_ff.operand_value;
      stat.out_free          = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // The fill count never passes the capacity.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pal_pkg::COUNT_W'(pal_pkg::CAPACITY))
      else $error("fill count above capacity");

   // A move write-back and a value write never share the write port.
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(mv_pend_ff && cmd.wr_val_en))
      else $error("two memory writes in one cycle");

   // A result is loaded only when the result register is free.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   // An insert that grows the list raises the fill count by one.
   a_inc_room: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_op == pal_pkg::CNT_INC |=> count_ff == $past(count_ff) + 7'd1)
      else $error("fill count increment lost");
`endif

endmodule

`default_nettype wire

[hw/rtl/pal_controller.sv]
// ============================================================================
// Positional array list controller
// State machine that sequences each command over the datapath.
// ============================================================================
`default_nettype none

module pal_controller (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  pal_pkg::stat_type  stat,
   output pal_pkg::cmd_type   cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DECIDE    = 4'd1;
   localparam logic [3:0] S_INS_SHIFT = 4'd2;
   localparam logic [3:0] S_INS_WRITE = 4'd3;
   localparam logic [3:0] S_DEL_SHIFT = 4'd4;
   localparam logic [3:0] S_SRCH_RD   = 4'd5;
   localparam logic [3:0] S_SRCH_CMP  = 4'd6;
   localparam logic [3:0] S_DISP_RD   = 4'd7;
   localparam logic [3:0] S_DISP_EMIT = 4'd8;
   localparam logic [3:0] S_RESULT    = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [2:0] code_ff, code_in;
   logic       found_ff, found_in;

   assign req_ready = state_ff == S_IDLE;

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      found_in = found_ff;

      cmd             = '0;
      cmd.ptr_op      = pal_pkg::PTR_HOLD;
      cmd.cnt_op      = pal_pkg::CNT_HOLD;
      cmd.rd_sel      = pal_pkg::RD_PTR;
      cmd.status      = pal_pkg::ST_OK;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               found_in     = 1'b0;
               state_in     = S_DECIDE;
            end
         end

         // Check the command against the list and pick the walk
         S_DECIDE: begin
            state_in = S_RESULT;
            case (stat.op)
               pal_pkg::OP_INSERT: begin
                  if (stat.pos_gt_count) begin
                     code_in = pal_pkg::ST_BADPOS;
                  end else if (stat.count_full) begin
                     code_in = pal_pkg::ST_FULL;
                  end else begin
                     cmd.ptr_op = pal_pkg::PTR_COUNT;
                     state_in   = S_INS_SHIFT;
                  end
               end
               pal_pkg::OP_DELETE: begin
                  if (stat.count_zero) begin
                     code_in = pal_pkg::ST_EMPTY;
                  end else if (stat.pos_ge_count) begin
                     code_in = pal_pkg::ST_BADPOS;
                  end else begin
                     cmd.ptr_op = pal_pkg::PTR_POS;
                     state_in   = S_DEL_SHIFT;
                  end
               end
               pal_pkg::OP_SEARCH: begin
                  if (stat.count_zero) begin
                     code_in = pal_pkg::ST_NOTFOUND;
                  end else begin
                     cmd.ptr_op = pal_pkg::PTR_ZERO;
                     state_in   = S_SRCH_RD;
                  end
               end
               pal_pkg::OP_UPDATE: begin
                  if (stat.count_zero) begin
                     code_in = pal_pkg::ST_EMPTY;
                  end else if (stat.pos_ge_count) begin
                     code_in = pal_pkg::ST_BADPOS;
                  end else begin
                     cmd.wr_val_en = 1'b1;
                     code_in       = pal_pkg::ST_OK;
                  end
               end
               pal_pkg::OP_DISPLAY: begin
                  if (stat.count_zero) begin
                     code_in = pal_pkg::ST_EMPTY;
                  end else begin
                     cmd.ptr_op = pal_pkg::PTR_ZERO;
                     state_in   = S_DISP_RD;
                  end
               end
               default: begin
                  code_in = pal_pkg::ST_BADPOS;
               end
            endcase
         end

         // Move entries up one slot, from the top down to the position
         S_INS_SHIFT: begin
            if (stat.ptr_gt_pos) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = pal_pkg::RD_PREV;
               cmd.mv_en  = 1'b1;
               cmd.ptr_op = pal_pkg::PTR_DEC;
            end else begin
               state_in = S_INS_WRITE;
            end
         end

         S_INS_WRITE: begin
            cmd.wr_val_en = 1'b1;
            cmd.cnt_op    = pal_pkg::CNT_INC;
            code_in       = pal_pkg::ST_OK;
            state_in      = S_RESULT;
         end

         // Move entries down one slot to close the gap
         S_DEL_SHIFT: begin
            if (stat.ptr_next_lt_count) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = pal_pkg::RD_NEXT;
               cmd.mv_en  = 1'b1;
               cmd.ptr_op = pal_pkg::PTR_INC;
            end else begin
               cmd.cnt_op = pal_pkg::CNT_DEC;
               code_in    = pal_pkg::ST_OK;
               state_in   = S_RESULT;
            end
         end

         S_SRCH_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_SRCH_CMP;
         end

         // Compare one entry with the key
         S_SRCH_CMP: begin
            if (stat.key_match) begin
               code_in  = pal_pkg::ST_OK;
               found_in = 1'b1;
               state_in = S_RESULT;
            end else if (stat.ptr_next_lt_count) begin
               cmd.ptr_op = pal_pkg::PTR_INC;
               state_in   = S_SRCH_RD;
            end else begin
               code_in  = pal_pkg::ST_NOTFOUND;
               state_in = S_RESULT;
            end
         end

         S_DISP_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_DISP_EMIT;
         end

         // Send one entry once the result register is free
         S_DISP_EMIT: begin
            if (stat.out_free) begin
               cmd.emit        = 1'b1;
               cmd.status      = pal_pkg::ST_OK;
               cmd.use_element = 1'b1;
               cmd.last        = !stat.ptr_next_lt_count;
               if (stat.ptr_next_lt_count) begin
                  cmd.ptr_op = pal_pkg::PTR_INC;
                  state_in   = S_DISP_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         S_RESULT: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.status    = code_ff;
               cmd.use_found = found_ff;
               cmd.last      = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

endmodule

`default_nettype wire

[hw/rtl/positional_array_list.sv]
// ============================================================================
// Positional array list
// Ordered list of up to 64 signed words with insert, delete, search, update
// and display commands.
// ============================================================================
// Usage: a command transaction enters on req_* when req_ready is high, which
// is whenever no earlier command is still being worked on. Each command gives
// one result transaction on rsp_*, except display of a non-empty list, which
// gives one per entry with end_of_run set on the last.
// Update, rejected commands and no-op cases go straight from the check to the
// result; insert moves the entries at and above the position up one at a time
// before writing, delete moves the entries above the position down one at a
// time, search reads and compares entries in order and display reads and
// loads one entry at a time. The memory takes one read and one write a cycle;
// the next command is accepted in the cycle after its last result loads.
// A finished result waits in an output register while the next command is
// accepted; when rsp_ready stays low the block holds its result and the walk
// pauses until the register is free. Reset clears the fill count, leaves the
// list empty and drops any pending result; no clearing pass is needed.
// ============================================================================
`default_nettype none

module positional_array_list (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  pal_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output pal_pkg::rsp_type   rsp_data
);

   pal_pkg::cmd_type  cmd;
   pal_pkg::stat_type stat;

   // Command sequencer
   pal_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Entry storage and result path
   pal_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[tb/pal_monitor.sv]
// ----------------------------------------------------------------------------
// Positional array list monitor
// Watches the command and result channels of the list block, keeps its own
// copy of the list to work out the results each command should give, and
// compares every result transaction field by field in arrival order.
// ----------------------------------------------------------------------------

module pal_monitor (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  pal_pkg::req_type  req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  pal_pkg::rsp_type  rsp_data,
   output logic [6:0]        list_size,
   output int                awaited_count,
   output int                mismatch_count
);

   // Shadow copy of the list contents and its fill count.
   logic signed [31:0] list_words [pal_pkg::CAPACITY];
   int unsigned        word_count;
   pal_pkg::rsp_type   awaited_results [$];
   int                 failures = 0;

   // Queue one expected result; the fill count is the one after the command.
   function automatic void push_result(input logic [2:0] status,
                                       input logic [5:0] found,
                                       input logic signed [31:0] word,
                                       input logic last);
      pal_pkg::rsp_type r;
      r.status      = status;
      r.found_index = found;
      r.element     = word;
      r.fill_count  = word_count[6:0];
      r.end_of_run  = last;
      awaited_results.push_back(r);
   endfunction

   // Apply one accepted command to the shadow list and queue its results.
   function automatic void apply_command(input pal_pkg::req_type cmd);
      int unsigned pos;
      int unsigned i;
      int unsigned hit;
      bit          found;
      pos   = cmd.position;
      found = 1'b0;
      hit   = 0;
      case (cmd.op)
         pal_pkg::OP_INSERT: begin
            // A position past the end is rejected before the full check.
            if (pos > word_count) begin
               push_result(pal_pkg::ST_BADPOS, '0, '0, 1'b1);
            end else if (word_count >= pal_pkg::CAPACITY) begin
               push_result(pal_pkg::ST_FULL, '0, '0, 1'b1);
            end else begin
               for (i = word_count; i > pos; i--) list_words[i] = list_words[i - 1];
               list_words[pos] = cmd.operand_value;
               word_count++;
               push_result(pal_pkg::ST_OK, '0, '0, 1'b1);
            end
         end
         pal_pkg::OP_DELETE: begin
            if (word_count == 0) begin
               push_result(pal_pkg::ST_EMPTY, '0, '0, 1'b1);
            end else if (pos >= word_count) begin
               push_result(pal_pkg::ST_BADPOS, '0, '0, 1'b1);
            end else begin
               for (i = pos; i + 1 < word_count; i++) list_words[i] = list_words[i + 1];
               word_count--;
               push_result(pal_pkg::ST_OK, '0, '0, 1'b1);
            end
         end
         pal_pkg::OP_SEARCH: begin
            // Only the first matching position is reported.
            for (i = 0; i < word_count && !found; i++) begin
               if (list_words[i] == cmd.operand_value) begin
                  found = 1'b1;
                  hit   = i;
               end
            end
            if (found) push_result(pal_pkg::ST_OK, hit[5:0], '0, 1'b1);
            else push_result(pal_pkg::ST_NOTFOUND, '0, '0, 1'b1);
         end
         pal_pkg::OP_UPDATE: begin
            if (word_count == 0) begin
               push_result(pal_pkg::ST_EMPTY, '0, '0, 1'b1);
            end else if (pos >= word_count) begin
               push_result(pal_pkg::ST_BADPOS, '0, '0, 1'b1);
            end else begin
               list_words[pos] = cmd.operand_value;
               push_result(pal_pkg::ST_OK, '0, '0, 1'b1);
            end
         end
         pal_pkg::OP_DISPLAY: begin
            // One result per entry, with the last one marked.
            if (word_count == 0) begin
               push_result(pal_pkg::ST_EMPTY, '0, '0, 1'b1);
            end else begin
               for (i = 0; i < word_count; i++) begin
                  push_result(pal_pkg::ST_OK, '0, list_words[i], (i + 1 == word_count));
               end
            end
         end
         default: push_result(pal_pkg::ST_BADPOS, '0, '0, 1'b1);
      endcase
   endfunction

   // Report one field that differs; returns 1 on a mismatch.
   function automatic bit field_differs(input string name, input longint want,
                                        input longint seen);
      if (want == seen) return 1'b0;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      return 1'b1;
   endfunction

   // Check a result transaction against the oldest expectation.
   function automatic void compare_result(input pal_pkg::rsp_type seen);
      pal_pkg::rsp_type want;
      bit               bad;
      if (awaited_results.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual status %0d index %0d",
                  $time, seen.status, seen.found_index);
         failures++;
      end else begin
         want = awaited_results.pop_front();
         bad  = 1'b0;
         bad |= field_differs("status", want.status, seen.status);
         bad |= field_differs("found_index", want.found_index, seen.found_index);
         bad |= field_differs("element", want.element, seen.element);
         bad |= field_differs("fill_count", want.fill_count, seen.fill_count);
         bad |= field_differs("end_of_run", want.end_of_run, seen.end_of_run);
         if (bad) failures++;
      end
   endfunction

   // Results are checked before the command taken at the same edge is applied.
   always @(posedge clock) begin
      if (reset) begin
         word_count = 0;
         awaited_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) compare_result(rsp_data);
         if (req_valid && req_ready) apply_command(req_data);
      end
      list_size      <= word_count[6:0];
      awaited_count  <= awaited_results.size();
      mismatch_count <= failures;
   end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Positional array list testbench
// Drives directed and then phase-weighted random list commands with random
// gaps on both channels, including one long result stall, and reports the
// verdict from the mismatch count kept by the monitor.
// ----------------------------------------------------------------------------

module testbench;

   // Weighting of the random command mix.
   typedef enum {GROW_PHASE, CHURN_PHASE, SHRINK_PHASE} mix_type;

   localparam int PHASE_ITEMS  = 60;
   localparam int HOLD_OFF     = 400;
   localparam int HOLD_AT      = 200;
   localparam int DRAIN_CYCLES = 150;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid;
   logic             req_ready;
   pal_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   pal_pkg::rsp_type rsp_data;

   logic [6:0] list_size;
   int         awaited_count;
   int         mismatch_count;
   int         items_sent = 0;

   always #5 clock = ~clock;

   positional_array_list DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   pal_monitor monitor (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .list_size      (list_size),
      .awaited_count  (awaited_count),
      .mismatch_count (mismatch_count)
   );

   // Offer one command transaction after a random gap and wait for acceptance.
   task automatic issue(input logic [2:0] op, input logic [6:0] position,
                        input logic signed [31:0] value);
      int               gap;
      pal_pkg::req_type item;
      gap = ((items_sent / 40) % 3 == 2) ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      item.op            = op;
      item.position      = position;
      item.operand_value = value;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      items_sent++;
      @(negedge clock);
   endtask

   // Pick an operation according to the current mix; a few are unused codes.
   function automatic logic [2:0] choose_op(input mix_type kind);
      int roll;
      int t_ins;
      int t_del;
      int t_sea;
      int t_upd;
      roll = $urandom_range(0, 99);
      case (kind)
         GROW_PHASE:  begin t_ins = 70; t_del = 75; t_sea = 85; t_upd = 95; end
         CHURN_PHASE: begin t_ins = 36; t_del = 68; t_sea = 82; t_upd = 94; end
         default:     begin t_ins = 16; t_del = 80; t_sea = 90; t_upd = 97; end
      endcase
      if (roll < 4) return 3'($urandom_range(5, 7));
      if (roll < t_ins) return pal_pkg::OP_INSERT;
      if (roll < t_del) return pal_pkg::OP_DELETE;
      if (roll < t_sea) return pal_pkg::OP_SEARCH;
      if (roll < t_upd) return pal_pkg::OP_UPDATE;
      return pal_pkg::OP_DISPLAY;
   endfunction

   // Mostly legal positions, some at the edges, some anywhere in the field.
   function automatic logic [6:0] choose_position(input logic [2:0] op,
                                                  input int size);
      int roll;
      int top;
      roll = $urandom_range(0, 99);
      top  = (op == pal_pkg::OP_INSERT) ? size : ((size > 0) ? size - 1 : 0);
      if (roll < 12) return 7'($urandom_range(0, 127));
      if (roll < 20) return ($urandom_range(0, 1) != 0) ? 7'(top) : 7'd0;
      if (roll < 24) return 7'(size);
      return 7'($urandom_range(0, top));
   endfunction

   // A small pool makes search hits and duplicates likely.
   function automatic logic signed [31:0] choose_value();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return $signed(32'($urandom_range(0, 15))) - 32'sd8;
      if (roll < 50) begin
         case ($urandom_range(0, 3))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sd0;
            default: return -32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   // Command stimulus and final verdict.
   initial begin
      mix_type plan [8];
      logic [2:0] op;
      plan = '{GROW_PHASE, GROW_PHASE, CHURN_PHASE, SHRINK_PHASE,
               GROW_PHASE, CHURN_PHASE, SHRINK_PHASE, CHURN_PHASE};
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: every operation on an empty list first.
      issue(pal_pkg::OP_DISPLAY, 7'd0, 32'sd0);
      issue(pal_pkg::OP_DELETE, 7'd0, 32'sd0);
      issue(pal_pkg::OP_UPDATE, 7'd0, 32'sd1);
      issue(pal_pkg::OP_SEARCH, 7'd0, 32'sd5);
      // Insert past the end, including the widest position.
      issue(pal_pkg::OP_INSERT, 7'd1, 32'sd9);
      issue(pal_pkg::OP_INSERT, 7'd127, -32'sd1);
      // Build a short list at the front, back and middle with extreme values.
      issue(pal_pkg::OP_INSERT, 7'd0, 32'sh7FFF_FFFF);
      issue(pal_pkg::OP_INSERT, 7'd1, 32'sh8000_0000);
      issue(pal_pkg::OP_INSERT, 7'd1, -32'sd1);
      issue(pal_pkg::OP_INSERT, 7'd0, 32'sd0);
      issue(pal_pkg::OP_SEARCH, 7'd0, -32'sd1);
      issue(pal_pkg::OP_SEARCH, 7'd0, 32'sh7FFF_FFFF);
      issue(pal_pkg::OP_SEARCH, 7'd0, 32'sd12345);
      issue(pal_pkg::OP_UPDATE, 7'd3, 32'sd7);
      issue(pal_pkg::OP_UPDATE, 7'd4, 32'sd7);
      issue(pal_pkg::OP_UPDATE, 7'd64, 32'sd7);
      issue(pal_pkg::OP_DELETE, 7'd4, 32'sd0);
      issue(pal_pkg::OP_DELETE, 7'd0, 32'sd0);
      issue(pal_pkg::OP_DELETE, 7'd2, 32'sd0);
      issue(pal_pkg::OP_DISPLAY, 7'd0, 32'sd0);
      // Unused operation codes.
      issue(3'd5, 7'd64, -32'sd1);
      issue(3'd6, 7'd0, 32'sd0);
      issue(3'd7, 7'd127, 32'sh5555_5555);

      // Random phases; the opening growth phases drive the list to full.
      foreach (plan[p]) begin
         repeat (PHASE_ITEMS) begin
            op = choose_op(plan[p]);
            issue(op, choose_position(op, list_size), choose_value());
         end
      end
      req_valid <= 1'b0;

      while (awaited_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Result receiver with random stalls and one long hold-off.
   initial begin
      int gap;
      int taken;
      taken     = 0;
      rsp_ready = 1'b0;
      while (reset) @(negedge clock);
      rsp_ready <= 1'b1;
      forever begin
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         taken++;
         @(negedge clock);
         if (taken == HOLD_AT) gap = HOLD_OFF;
         else gap = ((taken / 50) % 3 == 1) ? 0 : $urandom_range(0, 3);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog for a hung run.
   initial begin
      #15_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
